### src/ilt_pkg.sv
// shared types and constants of the ini line tokenizer
`timescale 1ns / 1ps

package ilt_pkg;

   localparam int BYTE_W              = 8;
   localparam int POS_W               = 16;
   localparam int COUNT_W             = 12;
   localparam int BUFFER_SIZE_DEFAULT = 65536;

   localparam logic [COUNT_W-1:0] ENTRY_CAP_RESET = 12'd64;

   // payload bits of a result: one flag, six positions and the count
   localparam int RSP_PAYLOAD_W = 1 + 6 * POS_W + COUNT_W;
   localparam int RSP_DATA_W    = ((RSP_PAYLOAD_W + 7) / 8) * 8;

   localparam logic [BYTE_W-1:0] CHAR_NUL       = 8'h00;
   localparam logic [BYTE_W-1:0] CHAR_TAB       = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_LF        = 8'h0a;
   localparam logic [BYTE_W-1:0] CHAR_CR        = 8'h0d;
   localparam logic [BYTE_W-1:0] CHAR_SPACE     = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_HASH      = 8'h23;
   localparam logic [BYTE_W-1:0] CHAR_SEMICOLON = 8'h3b;
   localparam logic [BYTE_W-1:0] CHAR_EQUALS    = 8'h3d;
   localparam logic [BYTE_W-1:0] CHAR_LBRACKET  = 8'h5b;
   localparam logic [BYTE_W-1:0] CHAR_RBRACKET  = 8'h5d;

   // result kinds carried on tuser
   localparam logic RESULT_ENTRY = 1'b0;
   localparam logic RESULT_DONE  = 1'b1;

   typedef enum logic [4:0] {
      MODE_SKIP    = 5'b00001,
      MODE_COMMENT = 5'b00010,
      MODE_SECTION = 5'b00100,
      MODE_KEY     = 5'b01000,
      MODE_VALUE   = 5'b10000
   } mode_type;

   // first member sits in the highest bits, so section_present lands at bit 0
   typedef struct packed {
      logic [COUNT_W-1:0] num_entries;
      logic [POS_W-1:0]   value_length;
      logic [POS_W-1:0]   value_offset;
      logic [POS_W-1:0]   key_length;
      logic [POS_W-1:0]   key_offset;
      logic [POS_W-1:0]   section_length;
      logic [POS_W-1:0]   section_start;
      logic               section_present;
   } payload_type;

   typedef struct packed {
      logic        result_type;
      logic        last;
      payload_type payload;
   } result_type_s_type;

endpackage

### src/ini_line_tokenizer.sv
// ini line tokenizer: byte stream in, entry and done records out
`timescale 1ns / 1ps

// Takes an INI text buffer one byte per transfer on the req_ side and reports
// each complete key/value entry on the rsp_ side as offsets and lengths of the
// current section name, the key and the value. A NUL byte, a transfer with
// req_tlast high, or the byte at offset BUFFER_SIZE-1 closes the buffer: a
// pending value is reported first, then a done record with the entry count,
// and the next byte starts a new buffer at offset 0. The parse state is
// updated in the cycle the byte is taken, and its results go into a
// three-slot output queue and are offered from the next cycle on. A byte
// yields at most two results (an entry and a done record); the queue takes a
// new byte whenever it holds fewer than two results, so with the sink ready
// every cycle the block takes one byte per clock, except that it stalls after
// a byte that yields both an entry and a done record, and it keeps taking
// bytes while a single result waits at the output. csr_wr_data sets the
// entry cap; write it only while the block is idle.
module ini_line_tokenizer #(
   parameter int BUFFER_SIZE = ilt_pkg::BUFFER_SIZE_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // input byte stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ilt_pkg::BYTE_W-1:0]       req_tdata,   // data_byte
   input  logic                             req_tlast,   // end_of_buffer
   // result stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // section_present, section_start, section_length, key_offset, key_length,
   // value_offset, value_length, num_entries, zero fill
   output logic [ilt_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tuser,   // result_type
   output logic                             rsp_tlast,   // last
   // entry cap register
   input  logic                             csr_wr_en,
   input  logic [ilt_pkg::COUNT_W-1:0]      csr_wr_data
);
   import ilt_pkg::*;

   localparam int OFFSET_W = $clog2(BUFFER_SIZE);
   localparam logic [OFFSET_W-1:0] OFFSET_LAST = OFFSET_W'(BUFFER_SIZE - 1);
   localparam int QPTR_W = 2;

   // parse state
   mode_type            mode_ff, mode_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic                sec_valid_ff, sec_valid_in;
   logic [POS_W-1:0]    sec_begin_ff, sec_begin_in;
   logic [POS_W-1:0]    sec_size_ff, sec_size_in;
   logic [POS_W-1:0]    key_begin_ff, key_begin_in;
   logic [POS_W-1:0]    key_size_ff, key_size_in;
   logic [POS_W-1:0]    value_begin_ff, value_begin_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [COUNT_W-1:0]  max_ff;

   // output queue
   result_type_s_type   queue_ff [3];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W-1:0]   qcount_ff, qcount_in;

   // per byte decode
   logic [BYTE_W-1:0]        in_byte;
   logic [OFFSET_W+POS_W-1:0] off_wide;
   logic [POS_W-1:0]         off16, off16_inc, end_pos, value_end;
   logic                     non_nul, eob, close, below_limit, is_space;
   logic                     emit_lf, emit_close, emit_entry;
   mode_type                 mode_mid;
   logic                     sec_valid_mid;
   logic [POS_W-1:0]         sec_begin_mid, sec_size_mid, key_begin_mid;
   logic [POS_W-1:0]         key_size_mid, value_begin_mid;
   logic [COUNT_W-1:0]       count_final;
   payload_type              entry_pl, done_pl;
   result_type_s_type        entry_res, done_res, first_res;
   logic                     req_fire, rsp_fire, push_first, push_second;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      return (p == 2'd2) ? 2'd0 : p + 2'd1;
   endfunction

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   // room for the worst case of two results from one byte
   assign req_tready = (qcount_ff < 2'd2);

   always_comb begin
      in_byte   = req_tdata;
      off_wide  = {{POS_W{1'b0}}, offset_ff};
      off16     = off_wide[POS_W-1:0];
      off16_inc = off16 + 16'd1;
      non_nul   = (in_byte != CHAR_NUL);
      eob       = req_tlast || (offset_ff >= OFFSET_LAST);
      close     = !non_nul || eob;
      end_pos   = non_nul ? off16_inc : off16;
      below_limit = (count_ff < max_ff);
      is_space  = (in_byte == CHAR_SPACE) || (in_byte == CHAR_TAB) ||
                  (in_byte == CHAR_CR) || (in_byte == CHAR_LF);

      mode_mid        = mode_ff;
      sec_valid_mid   = sec_valid_ff;
      sec_begin_mid   = sec_begin_ff;
      sec_size_mid    = sec_size_ff;
      key_begin_mid   = key_begin_ff;
      key_size_mid    = key_size_ff;
      value_begin_mid = value_begin_ff;
      emit_lf         = 1'b0;

      // content bytes are ignored once the entry limit is hit
      if (non_nul && below_limit) begin
         unique case (mode_ff)
            MODE_SKIP: begin
               if (is_space) begin
                  mode_mid = MODE_SKIP;
               end else if ((in_byte == CHAR_SEMICOLON) || (in_byte == CHAR_HASH)) begin
                  mode_mid = MODE_COMMENT;
               end else if (in_byte == CHAR_LBRACKET) begin
                  sec_begin_mid = off16_inc;
                  mode_mid      = MODE_SECTION;
               end else if (in_byte == CHAR_EQUALS) begin
                  // empty key
                  key_begin_mid   = off16;
                  key_size_mid    = '0;
                  value_begin_mid = off16_inc;
                  mode_mid        = MODE_VALUE;
               end else begin
                  key_begin_mid = off16;
                  mode_mid      = MODE_KEY;
               end
            end
            MODE_COMMENT: begin
               if (in_byte == CHAR_LF) begin
                  mode_mid = MODE_SKIP;
               end
            end
            MODE_SECTION: begin
               if (in_byte == CHAR_RBRACKET) begin
                  sec_valid_mid = 1'b1;
                  sec_size_mid  = off16 - sec_begin_ff;
                  mode_mid      = MODE_SKIP;
               end
            end
            MODE_KEY: begin
               if (in_byte == CHAR_EQUALS) begin
                  key_size_mid    = off16 - key_begin_ff;
                  value_begin_mid = off16_inc;
                  mode_mid        = MODE_VALUE;
               end else if (in_byte == CHAR_LF) begin
                  // line without equals sign is dropped
                  mode_mid = MODE_SKIP;
               end
            end
            MODE_VALUE: begin
               if (in_byte == CHAR_LF) begin
                  emit_lf  = 1'b1;
                  mode_mid = MODE_SKIP;
               end
            end
            default: begin
               mode_mid = MODE_SKIP;
            end
         endcase
      end

      // a value still open when the buffer closes is flushed; an lf entry
      // returns to skip mode, so at most one entry per byte
      emit_close  = close && (mode_mid == MODE_VALUE) && below_limit;
      emit_entry  = emit_lf || emit_close;
      value_end   = emit_lf ? off16 : end_pos;
      count_final = emit_entry ? (count_ff + 12'd1) : count_ff;

      entry_pl.section_present = sec_valid_mid;
      entry_pl.section_start   = sec_valid_mid ? sec_begin_mid : '0;
      entry_pl.section_length  = sec_valid_mid ? sec_size_mid : '0;
      entry_pl.key_offset      = key_begin_mid;
      entry_pl.key_length      = key_size_mid;
      entry_pl.value_offset    = value_begin_mid;
      entry_pl.value_length    = value_end - value_begin_mid;
      entry_pl.num_entries     = count_ff + 12'd1;

      done_pl             = '0;
      done_pl.num_entries = count_final;

      entry_res.result_type = RESULT_ENTRY;
      entry_res.last        = !close;
      entry_res.payload     = entry_pl;
      done_res.result_type  = RESULT_DONE;
      done_res.last         = 1'b1;
      done_res.payload      = done_pl;
      first_res             = emit_entry ? entry_res : done_res;

      // next parse state, a closed buffer starts over
      if (close) begin
         mode_in        = MODE_SKIP;
         offset_in      = '0;
         sec_valid_in   = 1'b0;
         sec_begin_in   = '0;
         sec_size_in    = '0;
         key_begin_in   = '0;
         key_size_in    = '0;
         value_begin_in = '0;
         count_in       = '0;
      end else begin
         mode_in        = mode_mid;
         offset_in      = offset_ff + OFFSET_W'(1);
         sec_valid_in   = sec_valid_mid;
         sec_begin_in   = sec_begin_mid;
         sec_size_in    = sec_size_mid;
         key_begin_in   = key_begin_mid;
         key_size_in    = key_size_mid;
         value_begin_in = value_begin_mid;
         count_in       = count_final;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_SKIP;
         offset_ff      <= '0;
         sec_valid_ff   <= 1'b0;
         sec_begin_ff   <= '0;
         sec_size_ff    <= '0;
         key_begin_ff   <= '0;
         key_size_ff    <= '0;
         value_begin_ff <= '0;
         count_ff       <= '0;
      end else if (req_fire) begin
         mode_ff        <= mode_in;
         offset_ff      <= offset_in;
         sec_valid_ff   <= sec_valid_in;
         sec_begin_ff   <= sec_begin_in;
         sec_size_ff    <= sec_size_in;
         key_begin_ff   <= key_begin_in;
         key_size_ff    <= key_size_in;
         value_begin_ff <= value_begin_in;
         count_ff       <= count_in;
      end
   end

   // entry cap register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= ENTRY_CAP_RESET;
      end else if (csr_wr_en) begin
         max_ff <= csr_wr_data;
      end
   end

   // output queue: entry goes first, done right behind it
   assign push_first  = req_fire && (emit_entry || close);
   assign push_second = req_fire && emit_entry && close;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push_second) begin
         wr_ptr_in = ptr_next(ptr_next(wr_ptr_ff));
      end else if (push_first) begin
         wr_ptr_in = ptr_next(wr_ptr_ff);
      end
      rd_ptr_in = rsp_fire ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      qcount_in = qcount_ff + {1'b0, push_first} + {1'b0, push_second}
                  - {1'b0, rsp_fire};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         qcount_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         qcount_ff <= qcount_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_first) begin
         queue_ff[wr_ptr_ff] <= first_res;
      end
      if (push_second) begin
         queue_ff[ptr_next(wr_ptr_ff)] <= done_res;
      end
   end

   assign rsp_tvalid = (qcount_ff != '0);
   assign rsp_tuser  = queue_ff[rd_ptr_ff].result_type;
   assign rsp_tlast  = queue_ff[rd_ptr_ff].last;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_PAYLOAD_W){1'b0}}, queue_ff[rd_ptr_ff].payload};

endmodule

### src/ilt_checker.sv
// port checks for the ini line tokenizer, bound into the tokenizer module
`timescale 1ns / 1ps

module ilt_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [ilt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tuser,
   input logic                           rsp_tlast
);
   import ilt_pkg::*;

   localparam int COUNT_LSB = 1 + 6 * POS_W;

   // a stalled result holds still
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                   $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // a done record always ends its byte's results
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == RESULT_DONE) |-> rsp_tlast)
      else $error("done record without last");

   // an entry that is not last is flushed at close, done follows right away
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && (rsp_tuser == RESULT_ENTRY) && !rsp_tlast
      |=> rsp_tvalid && (rsp_tuser == RESULT_DONE))
      else $error("entry at close not followed by done");

   // done carries only the count
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == RESULT_DONE) |-> (rsp_tdata[COUNT_LSB-1:0] == '0))
      else $error("done record with nonzero positions");

endmodule

bind ini_line_tokenizer ilt_checker u_ilt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
